// ===== sv/ilpa_pkg.sv =====
`timescale 1ns / 1ps

package ilpa_pkg;

  localparam int ID_W  = 24;
  localparam int LVL_W = 8;

  localparam logic [ID_W-1:0] ID_MAX       = {ID_W{1'b1}};
  localparam logic [ID_W-1:0] START_ID_RST = ID_W'(1);

  typedef struct packed {
    logic [LVL_W-1:0] indent_level;
    logic             new_list;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0] comment_id;
    logic [ID_W-1:0] parent_id;
    logic            level_clamped;
  } out_t;

  // Broadcast from the top level to every stack cell.
  typedef struct packed {
    logic             we;     // transaction accepted this cycle
    logic             clear;  // new list: treat the stack as empty
    logic [LVL_W-1:0] lvl;    // effective level (0 when the stack is empty or on a new list)
    logic [ID_W-1:0]  id;     // id pushed at lvl
    logic [ID_W-1:0]  pad;    // top of stack, copied into gap entries
  } cell_ctrl_t;

endpackage

// ===== sv/ilpa_cell.sv =====
`timescale 1ns / 1ps

module ilpa_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ilpa_pkg::cell_ctrl_t          ctrl,
  input  logic                          occ_up,
  output logic                          occ,
  output logic [ilpa_pkg::ID_W-1:0]     sel_val
);

  logic                      occ_r;
  logic                      occ_nxt;
  logic [ilpa_pkg::ID_W-1:0] val_r;
  logic [ilpa_pkg::ID_W-1:0] val_nxt;
  logic                      occ_eff;
  logic                      occ_up_eff;
  logic [ilpa_pkg::LVL_W:0]  idx_w;
  logic [ilpa_pkg::LVL_W:0]  idx_p1;
  logic [ilpa_pkg::LVL_W:0]  lvl_w;
  logic                      sel;

  assign idx_w      = (ilpa_pkg::LVL_W + 1)'(IDX);
  assign idx_p1     = idx_w + 1'b1;
  assign lvl_w      = {1'b0, ctrl.lvl};
  assign occ_eff    = occ_r & ~ctrl.clear;
  assign occ_up_eff = occ_up & ~ctrl.clear;

  // This cell is the deepest occupied entry below the level: it supplies the parent.
  assign sel     = occ_eff && ((idx_p1 == lvl_w) || ((idx_p1 < lvl_w) && !occ_up_eff));
  assign sel_val = sel ? val_r : '0;
  assign occ     = occ_r;

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (ctrl.we) begin
      occ_nxt = (idx_w <= lvl_w);
      if (idx_w == lvl_w) begin
        val_nxt = ctrl.id;
      end else if ((idx_w < lvl_w) && !occ_eff) begin
        val_nxt = ctrl.pad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== sv/indent_level_parent_assigner_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    ilpa_pkg::in_t  (indent_level, new_list)
// out_      output     out_valid / out_ready  ilpa_pkg::out_t (comment_id, parent_id,
//                                                              level_clamped)
// cfg_      input      cfg_we                 cfg_wdata = start_id
//
// One transaction per cycle while the output is not stalled; each result appears in the cycle after acceptance.
// The parent lookup, stack update and id increment are all worked out in the
// accepting cycle across the row of stack cells.
// in_ready is low only while a result waits and out_ready is low.
// Synchronous active-low reset empties the stack and sets start_id and the next id to 1.

module indent_level_parent_assigner_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ilpa_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ilpa_pkg::out_t            out_data,
  input  logic                      cfg_we,
  input  logic [ilpa_pkg::ID_W-1:0] cfg_wdata
);

  localparam logic [ilpa_pkg::LVL_W-1:0] LVL_MAX = ilpa_pkg::LVL_W'(STACK_DEPTH - 1);

  logic [ilpa_pkg::ID_W-1:0]  start_id_r;
  logic [ilpa_pkg::ID_W-1:0]  next_id_r;
  logic [ilpa_pkg::ID_W-1:0]  next_id_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  ilpa_pkg::out_t             out_data_r;
  ilpa_pkg::out_t             out_data_nxt;

  logic                       in_fire;
  logic                       clamped;
  logic [ilpa_pkg::LVL_W-1:0] lvl;
  logic [ilpa_pkg::ID_W-1:0]  id;
  logic [ilpa_pkg::ID_W-1:0]  parent;
  logic [STACK_DEPTH-1:0]     occ_r;
  logic [ilpa_pkg::ID_W-1:0]  sel_val [STACK_DEPTH];
  ilpa_pkg::cell_ctrl_t       ctrl;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign clamped = (in_data.indent_level > LVL_MAX);
  // An empty stack pushes at the bottom whatever the level.
  assign lvl = (!occ_r[0] || in_data.new_list) ? '0 :
               (clamped ? LVL_MAX : in_data.indent_level);
  assign id  = in_data.new_list ? start_id_r : next_id_r;

  always_comb begin
    parent = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      parent = parent | sel_val[i];
    end
  end

  assign ctrl.we    = in_fire;
  assign ctrl.clear = in_data.new_list;
  assign ctrl.lvl   = lvl;
  assign ctrl.id    = id;
  assign ctrl.pad   = parent;

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic occ_up;
    if (g == STACK_DEPTH - 1) begin : g_last
      assign occ_up = 1'b0;
    end else begin : g_mid
      assign occ_up = occ_r[g+1];
    end
    ilpa_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .occ_up  (occ_up),
      .occ     (occ_r[g]),
      .sel_val (sel_val[g])
    );
  end

  always_comb begin
    next_id_nxt   = next_id_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      next_id_nxt                = (id == ilpa_pkg::ID_MAX) ? id : id + 1'b1;
      out_valid_nxt              = 1'b1;
      out_data_nxt.comment_id    = id;
      out_data_nxt.parent_id     = parent;
      out_data_nxt.level_clamped = clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_id_r  <= ilpa_pkg::START_ID_RST;
      next_id_r   <= ilpa_pkg::START_ID_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_id_r <= cfg_wdata;
      end
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Occupied cells always form a contiguous run from the bottom.
  a_occ_contig: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_r >> 1) & ~occ_r) == '0)
    else $error("stack occupancy has a hole");

  a_push_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> occ_r[0])
    else $error("bottom cell empty after a push");

  a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_root_parent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.indent_level == '0) |=> out_data_r.parent_id == '0)
    else $error("top-level comment got a nonzero parent");

endmodule
